### hdl/dmc_pkg.sv
// dmc_pkg: shared codes, defaults, controller/datapath interface types and
// small helper functions for the maze carver
// no dependencies
package dmc_pkg;

  localparam int DEF_MAX_GRID_WIDTH  = 64;
  localparam int DEF_MAX_GRID_HEIGHT = 64;
  localparam int DEF_STACK_DEPTH     = 4096;

  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;
  localparam int CFG_SIZE_W = 7;
  localparam int RGB_W      = 24;
  localparam int PIX_W      = 8;
  localparam int KIND_W     = 2;
  localparam int RND_W      = 8;

  localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] REG_PATH_RGB    = 2'd2;

  localparam logic [CFG_SIZE_W-1:0] RST_GRID_WIDTH  = 7'd16;
  localparam logic [CFG_SIZE_W-1:0] RST_GRID_HEIGHT = 7'd16;
  localparam logic [RGB_W-1:0]      RST_PATH_RGB    = 24'hFFFFFF;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic [KIND_W-1:0] KIND_CELL    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PASSAGE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ACK     = 2'd3;

  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_UP    = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  typedef struct packed {
    logic take;
    logic clr_step;
    logic init_push;
    logic load_top;
    logic probe;
    logic pick;
    logic emit_ack;
    logic emit_fin;
    logic emit_cell;
    logic emit_pass;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic clr_last;
    logic probe_last;
    logic out_free;
    logic none_free;
  } sts_t;

  // value modulo a neighbor count of one to four
  function automatic logic [1:0] rnd_mod(input logic [RND_W-1:0] rnd, input logic [2:0] n);
    logic [3:0] s;
    logic [1:0] r;
    s = 4'(rnd[1:0]) + 4'(rnd[3:2]) + 4'(rnd[5:4]) + 4'(rnd[7:6]);
    if (s >= 4'd6) s = s - 4'd6;
    if (s >= 4'd3) s = s - 4'd3;
    if (s >= 4'd3) s = s - 4'd3;
    case (n)
      3'd2:    r = {1'b0, rnd[0]};
      3'd3:    r = s[1:0];
      3'd4:    r = rnd[1:0];
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // direction of the k-th set bit of the free-neighbor mask
  function automatic logic [1:0] pick_nth(input logic [3:0] mask, input logic [1:0] k);
    logic [2:0] seen;
    logic [1:0] d;
    seen = 3'd0;
    d = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        if (seen == {1'b0, k}) d = 2'(i);
        seen = seen + 3'd1;
      end
    end
    return d;
  endfunction

endpackage

### hdl/dmc_ctrl.sv
// dmc_ctrl: sequencing state machine for start, clear sweep and walk steps
// depends on dmc_pkg for cmd_t, sts_t and opcode values
module dmc_ctrl
  import dmc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_opcode_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CLR   = 4'd1;
  localparam logic [3:0] ST_INIT  = 4'd2;
  localparam logic [3:0] ST_ACK   = 4'd3;
  localparam logic [3:0] ST_FIN   = 4'd4;
  localparam logic [3:0] ST_LOAD  = 4'd5;
  localparam logic [3:0] ST_PROBE = 4'd6;
  localparam logic [3:0] ST_WAIT  = 4'd7;
  localparam logic [3:0] ST_PICK  = 4'd8;
  localparam logic [3:0] ST_CELL  = 4'd9;
  localparam logic [3:0] ST_PASS  = 4'd10;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (in_opcode_i == OP_START) state_d = ST_CLR;
          else if (sts_i.count_zero) state_d = ST_FIN;
          else state_d = ST_LOAD;
        end
      end
      ST_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = ST_INIT;
      end
      ST_INIT: begin
        cmd_o.init_push = 1'b1;
        state_d = ST_ACK;
      end
      ST_ACK: begin
        if (sts_i.out_free) begin
          cmd_o.emit_ack = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.emit_fin = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_LOAD: begin
        cmd_o.load_top = 1'b1;
        state_d = ST_PROBE;
      end
      ST_PROBE: begin
        cmd_o.probe = 1'b1;
        if (sts_i.probe_last) state_d = ST_WAIT;
      end
      ST_WAIT: begin
        state_d = ST_PICK;
      end
      ST_PICK: begin
        cmd_o.pick = 1'b1;
        state_d = ST_CELL;
      end
      ST_CELL: begin
        if (sts_i.out_free) begin
          cmd_o.emit_cell = 1'b1;
          state_d = sts_i.none_free ? ST_IDLE : ST_PASS;
        end
      end
      ST_PASS: begin
        if (sts_i.out_free) begin
          cmd_o.emit_pass = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hdl/dmc_datapath.sv
// dmc_datapath: config registers, visited map, cell stack, neighbor probe
// and result register; driven by dmc_ctrl through cmd_t / sts_t
// depends on dmc_pkg
module dmc_datapath
  import dmc_pkg::*;
#(
  parameter int MAX_GRID_WIDTH  = DEF_MAX_GRID_WIDTH,
  parameter int MAX_GRID_HEIGHT = DEF_MAX_GRID_HEIGHT,
  parameter int STACK_DEPTH     = DEF_STACK_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [RND_W-1:0]  in_random_value_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [KIND_W-1:0] out_kind_o,
  output logic [PIX_W-1:0]  out_pixel_x_o,
  output logic [PIX_W-1:0]  out_pixel_y_o,
  output logic [RGB_W-1:0]  out_pixel_color_o,
  output logic              out_last_o
);

  localparam int XW    = $clog2(MAX_GRID_WIDTH);
  localparam int YW    = $clog2(MAX_GRID_HEIGHT);
  localparam int NCELL = MAX_GRID_WIDTH * MAX_GRID_HEIGHT;
  localparam int AW    = $clog2(NCELL);
  localparam int SAW   = $clog2(STACK_DEPTH);
  localparam int CW    = $clog2(STACK_DEPTH + 1);
  localparam int WUW   = $clog2(MAX_GRID_WIDTH + 1);
  localparam int HUW   = $clog2(MAX_GRID_HEIGHT + 1);
  localparam int UW0   = (WUW > HUW) ? WUW : HUW;
  localparam int UW    = (UW0 > CFG_SIZE_W) ? UW0 : CFG_SIZE_W;
  localparam int CRW   = (XW > YW) ? XW : YW;
  localparam int PXW   = (CRW + 2 > PIX_W) ? CRW + 2 : PIX_W;
  localparam int SEW   = XW + YW;

  // configuration
  logic [CFG_SIZE_W-1:0] cfg_w_q, cfg_h_q;
  logic [RGB_W-1:0]      cfg_rgb_q;
  logic                  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q   <= RST_GRID_WIDTH;
      cfg_h_q   <= RST_GRID_HEIGHT;
      cfg_rgb_q <= RST_PATH_RGB;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_GRID_WIDTH:  cfg_w_q   <= pwdata[CFG_SIZE_W-1:0];
        REG_GRID_HEIGHT: cfg_h_q   <= pwdata[CFG_SIZE_W-1:0];
        REG_PATH_RGB:    cfg_rgb_q <= pwdata[RGB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_GRID_WIDTH:  prdata = APB_DW'(cfg_w_q);
      REG_GRID_HEIGHT: prdata = APB_DW'(cfg_h_q);
      REG_PATH_RGB:    prdata = APB_DW'(cfg_rgb_q);
      default:         prdata = '0;
    endcase
  end

  // clamped sizes
  logic [UW-1:0] w_raw, h_raw, w_used, h_used;
  assign w_raw = UW'(cfg_w_q);
  assign h_raw = UW'(cfg_h_q);

  always_comb begin
    if (w_raw == '0) w_used = UW'(1);
    else if (w_raw > UW'(MAX_GRID_WIDTH)) w_used = UW'(MAX_GRID_WIDTH);
    else w_used = w_raw;
    if (h_raw == '0) h_used = UW'(1);
    else if (h_raw > UW'(MAX_GRID_HEIGHT)) h_used = UW'(MAX_GRID_HEIGHT);
    else h_used = h_raw;
  end

  logic [XW-1:0] ctr_x;
  logic [YW-1:0] ctr_y;
  assign ctr_x = XW'(w_used >> 1);
  assign ctr_y = YW'(h_used >> 1);

  function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x, input logic [YW-1:0] y);
    return AW'(AW'(y) * AW'(MAX_GRID_WIDTH)) + AW'(x);
  endfunction

  // walk state
  logic [RND_W-1:0] rnd_q;
  logic [AW-1:0]    clr_q;
  logic [CW-1:0]    count_q;
  logic [XW-1:0]    cx_q;
  logic [YW-1:0]    cy_q;
  logic [1:0]       dir_q, pdir_q, sel_dir_q;
  logic             pvalid_q, pexist_q, none_q;
  logic [3:0]       mask_q;

  // neighbor of the current cell
  logic [1:0]    nb_dir;
  logic [XW-1:0] nb_x;
  logic [YW-1:0] nb_y;
  logic          nb_exist;

  assign nb_dir = cmd_i.emit_pass ? sel_dir_q : dir_q;

  always_comb begin
    nb_x = cx_q;
    nb_y = cy_q;
    case (nb_dir)
      DIR_LEFT:  nb_x = cx_q - XW'(1);
      DIR_UP:    nb_y = cy_q - YW'(1);
      DIR_RIGHT: nb_x = cx_q + XW'(1);
      DIR_DOWN:  nb_y = cy_q + YW'(1);
      default: ;
    endcase
    case (dir_q)
      DIR_LEFT:  nb_exist = (cx_q != '0);
      DIR_UP:    nb_exist = (cy_q != '0);
      DIR_RIGHT: nb_exist = (UW'(cx_q) + UW'(1)) < w_used;
      DIR_DOWN:  nb_exist = (UW'(cy_q) + UW'(1)) < h_used;
      default:   nb_exist = 1'b0;
    endcase
  end

  // visited map: one write and one read port
  logic          vis_mem [NCELL];
  logic          vis_we, vis_wd, vis_rd_q;
  logic [AW-1:0] vis_wa, vis_ra;

  assign vis_ra = cell_addr(nb_x, nb_y);

  always_comb begin
    vis_we = 1'b0;
    vis_wd = 1'b0;
    vis_wa = clr_q;
    if (cmd_i.clr_step) begin
      vis_we = 1'b1;
    end else if (cmd_i.init_push) begin
      vis_we = 1'b1;
      vis_wd = 1'b1;
      vis_wa = cell_addr(ctr_x, ctr_y);
    end else if (cmd_i.emit_pass) begin
      vis_we = 1'b1;
      vis_wd = 1'b1;
      vis_wa = vis_ra;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    vis_rd_q <= vis_mem[vis_ra];
  end

  // cell stack, entries hold {y, x}
  logic [SEW-1:0] stk_mem [STACK_DEPTH];
  logic [SEW-1:0] stk_rd_q, stk_wd;
  logic [SAW-1:0] stk_wa, stk_ra;
  logic           stk_we, stk_room;
  logic [CW-1:0]  count_m1;

  assign count_m1 = count_q - CW'(1);
  assign stk_ra   = count_m1[SAW-1:0];
  assign stk_room = count_q < CW'(STACK_DEPTH);

  always_comb begin
    stk_we = 1'b0;
    stk_wa = count_q[SAW-1:0];
    stk_wd = {nb_y, nb_x};
    if (cmd_i.init_push) begin
      stk_we = 1'b1;
      stk_wa = '0;
      stk_wd = {ctr_y, ctr_x};
    end else if (cmd_i.emit_pass && stk_room) begin
      stk_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_rd_q <= stk_mem[stk_ra];
  end

  // pick of the chosen free neighbor
  logic [2:0] free_cnt;
  logic [1:0] pick_k;
  assign free_cnt = 3'($countones(mask_q));
  assign pick_k   = rnd_mod(rnd_q, free_cnt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      clr_q    <= '0;
      dir_q    <= '0;
      pvalid_q <= 1'b0;
    end else begin
      pvalid_q <= cmd_i.probe;
      if (cmd_i.take) clr_q <= '0;
      else if (cmd_i.clr_step) clr_q <= clr_q + AW'(1);
      if (cmd_i.load_top) dir_q <= '0;
      else if (cmd_i.probe) dir_q <= dir_q + 2'd1;
      if (cmd_i.init_push) count_q <= CW'(1);
      else if (cmd_i.emit_cell && none_q) count_q <= count_m1;
      else if (cmd_i.emit_pass && stk_room) count_q <= count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) rnd_q <= in_random_value_i;
    if (cmd_i.load_top) begin
      cx_q <= stk_rd_q[XW-1:0];
      cy_q <= stk_rd_q[SEW-1:XW];
    end
    pdir_q   <= dir_q;
    pexist_q <= nb_exist;
    if (cmd_i.load_top) mask_q <= '0;
    else if (pvalid_q) mask_q[pdir_q] <= pexist_q & ~vis_rd_q;
    if (cmd_i.pick) begin
      sel_dir_q <= pick_nth(mask_q, pick_k);
      none_q    <= (mask_q == 4'd0);
    end
  end

  // pixel coordinates
  logic [PXW-1:0] x2, y2, cell_px, cell_py, pass_px, pass_py;
  assign x2      = PXW'({cx_q, 1'b0});
  assign y2      = PXW'({cy_q, 1'b0});
  assign cell_px = x2 + PXW'(1);
  assign cell_py = y2 + PXW'(1);

  always_comb begin
    pass_px = cell_px;
    pass_py = cell_py;
    case (sel_dir_q)
      DIR_LEFT:  pass_px = x2;
      DIR_UP:    pass_py = y2;
      DIR_RIGHT: pass_px = x2 + PXW'(2);
      DIR_DOWN:  pass_py = y2 + PXW'(2);
      default: ;
    endcase
  end

  // result register
  logic              out_valid_q, out_free;
  logic [KIND_W-1:0] out_kind_q;
  logic [PIX_W-1:0]  out_x_q, out_y_q;
  logic [RGB_W-1:0]  out_color_q;
  logic              out_last_q;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_ack || cmd_i.emit_fin || cmd_i.emit_cell || cmd_i.emit_pass) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_ack || cmd_i.emit_fin) begin
      out_kind_q  <= cmd_i.emit_ack ? KIND_ACK : KIND_DONE;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_color_q <= '0;
      out_last_q  <= 1'b1;
    end else if (cmd_i.emit_cell) begin
      out_kind_q  <= KIND_CELL;
      out_x_q     <= cell_px[PIX_W-1:0];
      out_y_q     <= cell_py[PIX_W-1:0];
      out_color_q <= cfg_rgb_q;
      out_last_q  <= none_q;
    end else if (cmd_i.emit_pass) begin
      out_kind_q  <= KIND_PASSAGE;
      out_x_q     <= pass_px[PIX_W-1:0];
      out_y_q     <= pass_py[PIX_W-1:0];
      out_color_q <= cfg_rgb_q;
      out_last_q  <= 1'b1;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_kind_o        = out_kind_q;
  assign out_pixel_x_o     = out_x_q;
  assign out_pixel_y_o     = out_y_q;
  assign out_pixel_color_o = out_color_q;
  assign out_last_o        = out_last_q;

  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.clr_last   = (clr_q == AW'(NCELL - 1));
  assign sts_o.probe_last = (dir_q == DIR_DOWN);
  assign sts_o.out_free   = out_free;
  assign sts_o.none_free  = none_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STACK_DEPTH))
    else $error("stack count above depth");

  a_emit_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.emit_ack, cmd_i.emit_fin, cmd_i.emit_cell, cmd_i.emit_pass}))
    else $error("more than one result loaded at once");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_ack || cmd_i.emit_fin || cmd_i.emit_cell || cmd_i.emit_pass) |-> out_free)
    else $error("result loaded over a pending transfer");

  a_pass_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_pass && stk_room) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("passage push did not grow the stack");
`endif

endmodule

### hdl/dfs_maze_carver_top.sv
// dfs_maze_carver_top: randomized depth-first maze generator
// instantiates dmc_ctrl and dmc_datapath, uses dmc_pkg
//
// input channel: in_valid_i / in_stall_o with in_opcode_i (start or step)
// and in_random_value_i. output channel: out_valid_o / out_stall_i with
// kind, pixel x/y, color and last; a step gives a cell pixel and, when a
// free neighbor exists, a passage pixel after it; last marks the final one.
// grid size and path color sit behind the apb port at 0x0, 0x4, 0x8.
// a start sweeps the visited map one cell per cycle, then pushes the
// center cell and gives an ack result.
// a step loads the top cell, then the single visited-map read port probes
// the four neighbors one after another; the block then picks a free
// neighbor and presents the cell pixel, and the passage pixel if it carves.
// a step on an empty stack gives the done result alone.
// one item is in flight at a time; in_stall_o is high while it is worked on.
// results sit in an output register, so the next item is taken while the
// last result still waits; a stalled receiver holds the block in its emit
// step until the pending transfer completes.
// reset clears the stack and control state and loads register defaults;
// the visited map is cleared by the next start.
module dfs_maze_carver_top
  import dmc_pkg::*;
#(
  parameter int MAX_GRID_WIDTH  = DEF_MAX_GRID_WIDTH,
  parameter int MAX_GRID_HEIGHT = DEF_MAX_GRID_HEIGHT,
  parameter int STACK_DEPTH     = DEF_STACK_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              in_opcode_i,
  input  logic [RND_W-1:0]  in_random_value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [KIND_W-1:0] out_kind_o,
  output logic [PIX_W-1:0]  out_pixel_x_o,
  output logic [PIX_W-1:0]  out_pixel_y_o,
  output logic [RGB_W-1:0]  out_pixel_color_o,
  output logic              out_last_o
);

  cmd_t cmd;
  sts_t sts;

  dmc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_opcode_i (in_opcode_i),
    .in_stall_o  (in_stall_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dmc_datapath #(
    .MAX_GRID_WIDTH  (MAX_GRID_WIDTH),
    .MAX_GRID_HEIGHT (MAX_GRID_HEIGHT),
    .STACK_DEPTH     (STACK_DEPTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .in_random_value_i (in_random_value_i),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_kind_o        (out_kind_o),
    .out_pixel_x_o     (out_pixel_x_o),
    .out_pixel_y_o     (out_pixel_y_o),
    .out_pixel_color_o (out_pixel_color_o),
    .out_last_o        (out_last_o)
  );

endmodule
